// ----- hw/rtl/mkdpc_pkg.sv -----
// shared types and constants of the multi-key debounce and press classifier
package mkdpc_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SETTLE_TICKS     = 2'd0,
    REG_LONG_PRESS_TICKS = 2'd1,
    REG_POLARITY_MASK    = 2'd2,
    REG_KEY_ENABLE_MASK  = 2'd3
  } cfg_reg_t;

  localparam logic [7:0] SETTLE_TICKS_RESET     = 8'd2;
  localparam logic [7:0] LONG_PRESS_TICKS_RESET = 8'd50;
  localparam logic [7:0] POLARITY_MASK_RESET    = 8'd0;
  localparam logic [7:0] KEY_ENABLE_MASK_RESET  = 8'd0;

  // event codes
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_DOWN    = 3'd1;
  localparam logic [2:0] EV_CLICK   = 3'd2;
  localparam logic [2:0] EV_LONG    = 3'd3;
  localparam logic [2:0] EV_LONG_UP = 3'd4;

  typedef enum logic [2:0] {
    ST_RELEASED = 3'b001,
    ST_PRESSED  = 3'b010,
    ST_LONG     = 3'b100
  } press_state_t;

  typedef struct packed {
    logic [2:0] key_index;
    logic       raw_level;
    logic       sample_valid;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_key;
    logic [2:0] key_event;
  } out_item_t;

  typedef struct packed {
    logic [7:0] settle_ticks;
    logic [7:0] long_press_ticks;
    logic [7:0] polarity_mask;
    logic [7:0] key_enable_mask;
  } cfg_t;

  // classified sample as it sits in the queue
  typedef struct packed {
    logic [2:0] key_index;
    logic       raw_level;
    logic       press_level;
    logic       active;
  } queue_entry_t;

  typedef struct packed {
    logic         previous_raw;
    logic [7:0]   stable_count;
    press_state_t press_state;
    logic [7:0]   hold_count;
  } key_rec_t;

  localparam key_rec_t REC_RESET = '{
    previous_raw: 1'b0,
    stable_count: 8'd0,
    press_state:  ST_RELEASED,
    hold_count:   8'd0
  };

  localparam int REC_W       = $bits(key_rec_t);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// ----- hw/rtl/mkdpc_ram.sv -----
// generic single-write, single-read ram with registered read data
module mkdpc_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read returns the old contents on an address collision
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/mkdpc_queue.sv -----
// two-entry queue of classified samples between front and back
module mkdpc_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  mkdpc_pkg::queue_entry_t wdata,
  output logic                    full,
  input  logic                    pop,
  output logic                    empty,
  output mkdpc_pkg::queue_entry_t rdata
);

  mkdpc_pkg::queue_entry_t entries [mkdpc_pkg::QUEUE_DEPTH];
  logic [mkdpc_pkg::QPTR_W-1:0] wr_ptr;
  logic [mkdpc_pkg::QPTR_W-1:0] rd_ptr;
  logic [mkdpc_pkg::QCNT_W-1:0] count;
  logic [mkdpc_pkg::QCNT_W-1:0] count_next;

  assign full  = (count == mkdpc_pkg::QCNT_W'(mkdpc_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- hw/rtl/mkdpc_front.sv -----
// front: takes samples and sorts out the ones that touch a key record
module mkdpc_front #(
  parameter int NUM_KEYS = 8
) (
  input  logic                    in_valid,
  output logic                    in_ready,
  input  mkdpc_pkg::in_item_t     in_data,
  input  mkdpc_pkg::cfg_t         cfg,
  input  logic                    q_full,
  output logic                    q_push,
  output mkdpc_pkg::queue_entry_t q_wdata
);

  logic in_range;
  logic key_on;

  assign in_range = (32'(in_data.key_index) < 32'(NUM_KEYS));
  assign key_on   = cfg.key_enable_mask[in_data.key_index];

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.key_index   = in_data.key_index;
    q_wdata.raw_level   = in_data.raw_level;
    q_wdata.press_level = cfg.polarity_mask[in_data.key_index];
    // invalid reads, disabled keys and keys past the last one leave all records alone
    q_wdata.active      = in_data.sample_valid && in_range && key_on;
  end

endmodule

// ----- hw/rtl/mkdpc_back.sv -----
// back: per-key record read-modify-write, press state machine and result register
module mkdpc_back #(
  parameter int NUM_KEYS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mkdpc_pkg::cfg_t         cfg,
  input  logic                    q_empty,
  input  mkdpc_pkg::queue_entry_t q_rdata,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output mkdpc_pkg::out_item_t    out_data
);

  localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic                       b_valid;
  mkdpc_pkg::queue_entry_t    b_item;
  logic                       b_byp;
  mkdpc_pkg::key_rec_t        b_byp_rec;
  logic                       b_vld;
  logic [NUM_KEYS-1:0]        vld;
  logic [mkdpc_pkg::REC_W-1:0] ram_rdata;

  logic                b_fire;
  logic                issue;
  logic [KEY_AW-1:0]   head_addr;
  logic [KEY_AW-1:0]   wr_addr;
  logic                wr_en;
  logic                pressed;
  logic [2:0]          ev;
  mkdpc_pkg::key_rec_t cur;
  mkdpc_pkg::key_rec_t nxt;

  assign head_addr = KEY_AW'(q_rdata.key_index);
  assign wr_addr   = KEY_AW'(b_item.key_index);
  assign b_fire    = b_valid && (!out_valid || out_ready);
  assign issue     = !q_empty && (!b_valid || b_fire);
  assign q_pop     = issue;
  assign wr_en     = b_fire && b_item.active;

  mkdpc_ram #(
    .WIDTH (mkdpc_pkg::REC_W),
    .DEPTH (NUM_KEYS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (nxt),
    .re    (issue && q_rdata.active),
    .raddr (head_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    // a write landing in the same cycle as the read is forwarded
    if (b_byp) begin
      cur = b_byp_rec;
    end else if (b_vld) begin
      cur = mkdpc_pkg::key_rec_t'(ram_rdata);
    end else begin
      cur = mkdpc_pkg::REC_RESET;
    end
    nxt     = cur;
    ev      = mkdpc_pkg::EV_NONE;
    pressed = (b_item.raw_level == b_item.press_level);
    if (b_item.raw_level != cur.previous_raw) begin
      nxt.stable_count = '0;
      nxt.previous_raw = b_item.raw_level;
    end else if (cur.stable_count < cfg.settle_ticks) begin
      nxt.stable_count = cur.stable_count + 8'd1;
    end else begin
      unique case (cur.press_state)
        mkdpc_pkg::ST_RELEASED: begin
          if (pressed) begin
            nxt.press_state = mkdpc_pkg::ST_PRESSED;
            nxt.hold_count  = '0;
            ev              = mkdpc_pkg::EV_DOWN;
          end
        end
        mkdpc_pkg::ST_PRESSED: begin
          if (pressed) begin
            if (cur.hold_count < cfg.long_press_ticks) begin
              nxt.hold_count = cur.hold_count + 8'd1;
            end else begin
              nxt.press_state = mkdpc_pkg::ST_LONG;
              ev              = mkdpc_pkg::EV_LONG;
            end
          end else begin
            nxt.press_state = mkdpc_pkg::ST_RELEASED;
            ev = (cur.hold_count < cfg.long_press_ticks) ? mkdpc_pkg::EV_CLICK
                                                         : mkdpc_pkg::EV_LONG_UP;
          end
        end
        mkdpc_pkg::ST_LONG: begin
          if (!pressed) begin
            nxt.press_state = mkdpc_pkg::ST_RELEASED;
            ev              = mkdpc_pkg::EV_LONG_UP;
          end
        end
        default: begin
          ev = mkdpc_pkg::EV_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
      vld       <= '0;
    end else begin
      if (issue) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_item    <= q_rdata;
      b_byp     <= wr_en && q_rdata.active && (wr_addr == head_addr);
      b_byp_rec <= nxt;
      b_vld     <= q_rdata.active && vld[head_addr];
    end
    if (b_fire) begin
      out_data.event_key <= b_item.key_index;
      out_data.key_event <= b_item.active ? ev : mkdpc_pkg::EV_NONE;
    end
  end

endmodule

// ----- hw/rtl/multi_key_debounce_press_classifier_unit.sv -----
// Key debounce and press classifier: one sampled level per transaction in, one event per
// transaction out, in order. Sustains one sample per clock while out_ready is held high. A sample
// goes through the queue write, the record read and the result register in that order; the
// record read is registered in the per-key record ram, and same-key samples in consecutive
// cycles are forwarded.
// Per-key records start released with cleared counters straight out of reset (valid bits,
// no clearing pass). Configuration writes are taken every cycle and should only be made
// while no sample is in flight.
module multi_key_debounce_press_classifier_unit #(
  parameter int NUM_KEYS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mkdpc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mkdpc_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data
);

  mkdpc_pkg::cfg_t         cfg;
  logic                    q_push;
  logic                    q_pop;
  logic                    q_full;
  logic                    q_empty;
  mkdpc_pkg::queue_entry_t q_wdata;
  mkdpc_pkg::queue_entry_t q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ticks     <= mkdpc_pkg::SETTLE_TICKS_RESET;
      cfg.long_press_ticks <= mkdpc_pkg::LONG_PRESS_TICKS_RESET;
      cfg.polarity_mask    <= mkdpc_pkg::POLARITY_MASK_RESET;
      cfg.key_enable_mask  <= mkdpc_pkg::KEY_ENABLE_MASK_RESET;
    end else if (cfg_valid) begin
      unique case (mkdpc_pkg::cfg_reg_t'(cfg_index))
        mkdpc_pkg::REG_SETTLE_TICKS:     cfg.settle_ticks     <= cfg_data;
        mkdpc_pkg::REG_LONG_PRESS_TICKS: cfg.long_press_ticks <= cfg_data;
        mkdpc_pkg::REG_POLARITY_MASK:    cfg.polarity_mask    <= cfg_data;
        mkdpc_pkg::REG_KEY_ENABLE_MASK:  cfg.key_enable_mask  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mkdpc_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  mkdpc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  mkdpc_back #(
    .NUM_KEYS (NUM_KEYS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- tb/multi_key_debounce_press_classifier_unit_test.sv -----
// self-checking testbench of the multi-key debounce and press classifier
`timescale 1ns / 1ps

module multi_key_debounce_press_classifier_unit_test;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_REPORTS   = 10;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  mkdpc_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  mkdpc_pkg::out_item_t out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  multi_key_debounce_press_classifier_unit #(
    .NUM_KEYS(8)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor copy of the registers and per-key records
  mkdpc_pkg::cfg_t         model_cfg;
  logic                    last_level [8];
  logic [7:0]              settle_cnt [8];
  mkdpc_pkg::press_state_t key_phase [8];
  logic [7:0]              hold_cnt [8];

  mkdpc_pkg::in_item_t  sample_q [$];
  mkdpc_pkg::out_item_t event_q [$];
  int        errors = 0;
  int        quiet_cycles = 0;
  int        send_wait = 0;
  int        recv_wait = 0;
  bit        no_idle = 1'b0;

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic mkdpc_pkg::out_item_t predict_event(mkdpc_pkg::in_item_t s);
    mkdpc_pkg::out_item_t r;
    logic [2:0]           k;
    logic                 pressed;
    k = s.key_index;
    r.event_key = k;
    r.key_event = mkdpc_pkg::EV_NONE;
    if (!s.sample_valid || !model_cfg.key_enable_mask[k]) return r;
    if (s.raw_level != last_level[k]) begin
      settle_cnt[k] = 8'd0;
      last_level[k] = s.raw_level;
      return r;
    end
    if (settle_cnt[k] < model_cfg.settle_ticks) begin
      settle_cnt[k] = settle_cnt[k] + 8'd1;
      return r;
    end
    pressed = (s.raw_level == model_cfg.polarity_mask[k]);
    case (key_phase[k])
      mkdpc_pkg::ST_RELEASED: begin
        if (pressed) begin
          key_phase[k] = mkdpc_pkg::ST_PRESSED;
          hold_cnt[k] = 8'd0;
          r.key_event = mkdpc_pkg::EV_DOWN;
        end
      end
      mkdpc_pkg::ST_PRESSED: begin
        if (pressed) begin
          if (hold_cnt[k] < model_cfg.long_press_ticks) begin
            hold_cnt[k] = hold_cnt[k] + 8'd1;
          end else begin
            key_phase[k] = mkdpc_pkg::ST_LONG;
            r.key_event = mkdpc_pkg::EV_LONG;
          end
        end else begin
          key_phase[k] = mkdpc_pkg::ST_RELEASED;
          r.key_event = (hold_cnt[k] < model_cfg.long_press_ticks) ? mkdpc_pkg::EV_CLICK
                                                                   : mkdpc_pkg::EV_LONG_UP;
        end
      end
      mkdpc_pkg::ST_LONG: begin
        if (!pressed) begin
          key_phase[k] = mkdpc_pkg::ST_RELEASED;
          r.key_event = mkdpc_pkg::EV_LONG_UP;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // sample driver
  always @(posedge clk) begin : tx_side
    logic fire;
    if (rst) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) event_q.push_back(predict_event(in_data));
      if (!in_valid || fire) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_data <= sample_q.pop_front();
          in_valid <= 1'b1;
          send_wait <= draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // event monitor
  always @(posedge clk) begin : rx_side
    int                   stall;
    mkdpc_pkg::out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else if (out_valid && out_ready) begin
      if (event_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected event transaction: key %0d event %0d",
                   out_data.event_key, out_data.key_event);
      end else begin
        want = event_q.pop_front();
        if (out_data.event_key !== want.event_key || out_data.key_event !== want.key_event) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("event mismatch: key exp %0d got %0d, event exp %0d got %0d",
                     want.event_key, out_data.event_key, want.key_event, out_data.key_event);
        end
      end
      stall = draw_gap();
      recv_wait <= stall;
      out_ready <= (stall == 0);
    end else if (!out_ready) begin
      if (recv_wait <= 1) begin
        out_ready <= 1'b1;
        recv_wait <= 0;
      end else begin
        recv_wait <= recv_wait - 1;
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_sample(logic [2:0] k, logic lvl, logic vld);
    mkdpc_pkg::in_item_t s;
    s.key_index = k;
    s.raw_level = lvl;
    s.sample_valid = vld;
    sample_q.push_back(s);
  endtask

  task automatic push_run(logic [2:0] k, logic lvl, int len);
    repeat (len) push_sample(k, lvl, 1'b1);
  endtask

  task automatic push_stray();
    push_sample(3'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_valid || event_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(mkdpc_pkg::cfg_reg_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      mkdpc_pkg::REG_SETTLE_TICKS:     model_cfg.settle_ticks = val;
      mkdpc_pkg::REG_LONG_PRESS_TICKS: model_cfg.long_press_ticks = val;
      mkdpc_pkg::REG_POLARITY_MASK:    model_cfg.polarity_mask = val;
      mkdpc_pkg::REG_KEY_ENABLE_MASK:  model_cfg.key_enable_mask = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [7:0] deb, logic [7:0] lpt, logic [7:0] act, logic [7:0] en);
    write_reg(mkdpc_pkg::REG_SETTLE_TICKS, deb);
    write_reg(mkdpc_pkg::REG_LONG_PRESS_TICKS, lpt);
    write_reg(mkdpc_pkg::REG_POLARITY_MASK, act);
    write_reg(mkdpc_pkg::REG_KEY_ENABLE_MASK, en);
  endtask

  // mostly same-level runs on one key, with stray samples mixed in
  task automatic random_phase(int n);
    int         pushed;
    int         len;
    logic [2:0] k;
    logic       lvl;
    pushed = 0;
    while (pushed < n) begin
      if ($urandom_range(0, 9) < 8) begin
        k = 3'($urandom_range(0, 7));
        lvl = 1'($urandom_range(0, 1));
        len = $urandom_range(1, model_cfg.settle_ticks + model_cfg.long_press_ticks + 4);
        repeat (len) begin
          push_sample(k, lvl, 1'b1);
          pushed++;
          if ($urandom_range(0, 19) == 0) begin
            push_stray();
            pushed++;
          end
        end
      end else begin
        push_stray();
        pushed++;
      end
    end
  endtask

  initial begin
    model_cfg.settle_ticks = mkdpc_pkg::SETTLE_TICKS_RESET;
    model_cfg.long_press_ticks = mkdpc_pkg::LONG_PRESS_TICKS_RESET;
    model_cfg.polarity_mask = mkdpc_pkg::POLARITY_MASK_RESET;
    model_cfg.key_enable_mask = mkdpc_pkg::KEY_ENABLE_MASK_RESET;
    for (int i = 0; i < 8; i++) begin
      last_level[i] = 1'b0;
      settle_cnt[i] = 8'd0;
      key_phase[i] = mkdpc_pkg::ST_RELEASED;
      hold_cnt[i] = 8'd0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // all keys disabled out of reset
    push_sample(3'd0, 1'b0, 1'b1);
    push_sample(3'd7, 1'b1, 1'b1);
    wait_idle();

    // directed: key 0 and 2 active high, key 1 disabled
    set_config(8'd1, 8'd2, 8'hA5, 8'hFD);
    push_run(3'd0, 1'b1, 7);      // change, settle, down, two holds, long, none
    push_sample(3'd0, 1'b0, 1'b0); // invalid sample
    push_run(3'd0, 1'b0, 3);      // long release
    push_sample(3'd1, 1'b1, 1'b1); // disabled key
    push_run(3'd2, 1'b1, 4);      // down then one hold
    push_run(3'd2, 1'b0, 3);      // click
    push_run(3'd2, 1'b1, 5);      // down, hold up to threshold
    push_run(3'd2, 1'b0, 3);      // release at threshold gives long release
    wait_idle();

    for (int p = 0; p < 11; p++) begin
      no_idle = (p % 4 == 3);
      case (p)
        0: set_config(8'd0, 8'd0, 8'($urandom), 8'hFF);
        1: set_config(8'd1, 8'd3, 8'h00, 8'hFF);
        2: set_config(8'd2, 8'd6, 8'hFF, 8'($urandom));
        4: set_config(8'd255, 8'd1, 8'($urandom), 8'hFF);
        5: set_config(8'd0, 8'd255, 8'hFF, 8'h20);
        6: set_config(8'($urandom_range(0, 3)), 8'($urandom_range(0, 12)), 8'($urandom),
                      8'h00);
        default: set_config(8'($urandom_range(0, 3)), 8'($urandom_range(0, 12)),
                            8'($urandom), 8'($urandom) | 8'h0F);
      endcase
      case (p)
        4: begin
          push_run(3'd4, 1'b1, 258);
          push_run(3'd4, 1'b0, 258);
        end
        5: begin
          push_run(3'd5, 1'b1, 260);
          push_run(3'd5, 1'b0, 3);
          random_phase(40);
        end
        6: random_phase(60);
        default: random_phase(100);
      endcase
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (event_q.size() != 0) begin
      errors++;
      $display("%0d event transactions never arrived", event_q.size());
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
